// ===== rtl/kdq_pkg.sv =====
// shared types and constants for the keyed deque
package kdq_pkg;

	localparam int KEY_W        = 64;
	localparam int FUNC_W       = 3;
	localparam int STAT_W       = 2;
	localparam int POS_W        = 4;
	localparam int OCC_W        = 5;
	localparam int DEF_CAPACITY = 16;

	localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
	localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd1;
	localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd2;
	localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd3;
	localparam logic [FUNC_W-1:0] FN_REMOVE     = 3'd4;
	localparam logic [FUNC_W-1:0] FN_FIND       = 3'd5;
	localparam logic [FUNC_W-1:0] FN_CLEAR      = 3'd6;

	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_INVALID   = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

	typedef struct packed {
		logic shr;
		logic shl_all;
		logic shl_hit;
		logic app;
	} cell_ctrl_t;

endpackage

// ===== rtl/kdq_cell.sv =====
// one deque slot: key register, key compare and neighbor shifting
module kdq_cell
	import kdq_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             match_en,
	input  logic [KEY_W-1:0] req_key,
	input  logic             live,
	input  logic             tail,
	input  cell_ctrl_t       ctrl,
	input  logic [KEY_W-1:0] left_key,
	input  logic [KEY_W-1:0] right_key,
	input  logic             hit_in,
	output logic [KEY_W-1:0] key,
	output logic             hit_out,
	output logic             first
);

	logic [KEY_W-1:0] key_q;
	logic             match_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (match_en) begin
			match_q <= live && (key_q == req_key);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shr) begin
			key_q <= left_key;
		end else if (ctrl.shl_all || (ctrl.shl_hit && hit_out)) begin
			key_q <= right_key;
		end else if (ctrl.app && tail) begin
			key_q <= req_key;
		end
	end

	assign key     = key_q;
	assign hit_out = hit_in | match_q;
	assign first   = match_q & ~hit_in;

endmodule

// ===== rtl/keyed_deque_with_removal.sv =====
// top level of the keyed deque: request decode, occupancy and the row of slots
//
// Double-ended queue of nonzero 64-bit keys, kept compacted with position 0
// at the front. A request (func, key) is taken at a clock edge where start
// is high and busy is low. Busy stays high for the one cycle in which the
// request is carried out; the result (status, key_out, position, occupancy)
// is then shown for exactly one cycle with done high. A new request can be
// taken while done is shown, but not while busy is high. The key compare runs
// in every slot in parallel at the accepting edge, and the first hit is found
// by a hit chain through the row of slots in the execute cycle, where slots
// shift toward their neighbors at once: all of them for push front and pop
// front, those from the hit onward for remove. Reset empties the queue (count
// zero) and clears busy and done; the slot contents and the occupancy output
// are not cleared, and slots are never shown before being written. The
// receiver cannot stall: each result is taken in its done cycle.
module keyed_deque_with_removal
	import kdq_pkg::*;
#(
	parameter int CAPACITY = DEF_CAPACITY
)(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [FUNC_W-1:0] func,
	input  logic [KEY_W-1:0]  key,
	output logic              busy,
	output logic              done,
	output logic [STAT_W-1:0] status,
	output logic [KEY_W-1:0]  key_out,
	output logic [POS_W-1:0]  position,
	output logic [OCC_W-1:0]  occupancy
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t            state_q;
	logic [FUNC_W-1:0] func_q;
	logic [KEY_W-1:0]  key_q;
	logic [CW-1:0]     count_q;
	logic              done_q;
	logic [STAT_W-1:0] status_q;
	logic [KEY_W-1:0]  key_out_q;
	logic [POS_W-1:0]  position_q;
	logic [OCC_W-1:0]  occupancy_q;

	logic              accept;
	logic              exec;
	cell_ctrl_t        ctrl;
	logic [STAT_W-1:0] stat_d;
	logic [KEY_W-1:0]  kout_d;
	logic [CW-1:0]     count_d;
	logic              found;
	logic [IW-1:0]     hit_idx;
	logic [KEY_W-1:0]  back_key;
	logic              key_zero;

	logic [KEY_W-1:0]  slot_key [CAPACITY];
	logic [CAPACITY:0] hit_w;
	logic [CAPACITY-1:0] first_w;
	logic [CAPACITY-1:0] live_w;
	logic [CAPACITY-1:0] tail_w;
	logic [CAPACITY-1:0] last_w;

	assign accept   = start && (state_q == S_IDLE);
	assign exec     = (state_q == S_EXEC);
	assign key_zero = (key_q == '0);
	assign hit_w[0] = 1'b0;

	genvar g;
	generate
		for (g = 0; g < CAPACITY; g++) begin : g_slot
			assign live_w[g] = (CW'(g) < count_q);
			assign tail_w[g] = (CW'(g) == count_q);
			assign last_w[g] = (CW'(g + 1) == count_q);

			kdq_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.match_en  (accept),
				.req_key   (accept ? key : key_q),
				.live      (live_w[g]),
				.tail      (tail_w[g]),
				.ctrl      (ctrl),
				.left_key  ((g == 0) ? key_q : slot_key[(g == 0) ? 0 : g - 1]),
				.right_key (slot_key[(g == CAPACITY - 1) ? g : g + 1]),
				.hit_in    (hit_w[g]),
				.key       (slot_key[g]),
				.hit_out   (hit_w[g+1]),
				.first     (first_w[g])
			);
		end
	endgenerate

	assign found = hit_w[CAPACITY];

	always_comb begin
		hit_idx  = '0;
		back_key = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (first_w[i]) begin
				hit_idx = hit_idx | IW'(i);
			end
			if (last_w[i]) begin
				back_key = back_key | slot_key[i];
			end
		end
	end

	always_comb begin
		ctrl    = '0;
		stat_d  = ST_OK;
		kout_d  = '0;
		count_d = count_q;
		case (func_q)
			FN_PUSH_FRONT, FN_PUSH_BACK: begin
				if (key_zero) begin
					stat_d = ST_INVALID;
				end else if (count_q == CW'(CAPACITY)) begin
					stat_d = ST_FULL;
				end else begin
					ctrl.shr = (func_q == FN_PUSH_FRONT);
					ctrl.app = (func_q == FN_PUSH_BACK);
					count_d  = count_q + 1'b1;
				end
			end
			FN_POP_FRONT: begin
				if (count_q == '0) begin
					stat_d = ST_INVALID;
				end else begin
					kout_d       = slot_key[0];
					ctrl.shl_all = 1'b1;
					count_d      = count_q - 1'b1;
				end
			end
			FN_POP_BACK: begin
				if (count_q == '0) begin
					stat_d = ST_INVALID;
				end else begin
					kout_d  = back_key;
					count_d = count_q - 1'b1;
				end
			end
			FN_REMOVE, FN_FIND: begin
				if (key_zero) begin
					stat_d = ST_INVALID;
				end else if (!found) begin
					stat_d = ST_NOT_FOUND;
				end else if (func_q == FN_REMOVE) begin
					ctrl.shl_hit = 1'b1;
					count_d      = count_q - 1'b1;
				end
			end
			FN_CLEAR: begin
				count_d = '0;
			end
			default: begin
				stat_d = ST_INVALID;
			end
		endcase
		if (!exec) begin
			ctrl = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= exec;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_IDLE;
					count_q <= count_d;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			key_q  <= key;
		end
		if (exec) begin
			status_q    <= stat_d;
			key_out_q   <= kout_d;
			position_q  <= (stat_d == ST_OK && (func_q == FN_REMOVE || func_q == FN_FIND))
				? POS_W'(hit_idx) : '0;
			occupancy_q <= OCC_W'(count_d);
		end
	end

	assign busy      = exec;
	assign done      = done_q;
	assign status    = status_q;
	assign key_out   = key_out_q;
	assign position  = position_q;
	assign occupancy = occupancy_q;

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while request still executing");

	a_accept_then_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy ##1 done)
		else $error("accepted request did not complete in two cycles");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("occupancy beyond capacity");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!exec |=> $stable(count_q))
		else $error("occupancy changed outside execute cycle");

endmodule

// ===== tb/kdq_checker.sv =====
// request and result monitor with deque predictor and result comparison
`timescale 1ns / 100ps

module kdq_checker
	import kdq_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  logic [FUNC_W-1:0] func,
	input  logic [KEY_W-1:0]  key,
	input  logic              done,
	input  logic [STAT_W-1:0] status,
	input  logic [KEY_W-1:0]  key_out,
	input  logic [POS_W-1:0]  position,
	input  logic [OCC_W-1:0]  occupancy,
	output int                fail_count,
	output int                pending_count
);

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [KEY_W-1:0]  key_out;
		logic [POS_W-1:0]  position;
		logic [OCC_W-1:0]  occupancy;
	} deque_result_t;

	logic [KEY_W-1:0] deque_keys[$];
	deque_result_t    expected_results[$];
	int               mismatch_count;

	function automatic deque_result_t apply_request(input logic [FUNC_W-1:0] f,
		input logic [KEY_W-1:0] k);
		deque_result_t r;
		int            hit;
		r = '0;
		r.status = ST_OK;
		hit = -1;
		case (f)
			FN_PUSH_FRONT, FN_PUSH_BACK: begin
				if (k == '0)
					r.status = ST_INVALID;
				else if (deque_keys.size() >= DEF_CAPACITY)
					r.status = ST_FULL;
				else if (f == FN_PUSH_FRONT)
					deque_keys.push_front(k);
				else
					deque_keys.push_back(k);
			end
			FN_POP_FRONT: begin
				if (deque_keys.size() == 0)
					r.status = ST_INVALID;
				else
					r.key_out = deque_keys.pop_front();
			end
			FN_POP_BACK: begin
				if (deque_keys.size() == 0)
					r.status = ST_INVALID;
				else
					r.key_out = deque_keys.pop_back();
			end
			FN_REMOVE, FN_FIND: begin
				if (k == '0) begin
					r.status = ST_INVALID;
				end else begin
					for (int i = 0; i < deque_keys.size(); i++)
						if (hit < 0 && deque_keys[i] == k)
							hit = i;
					if (hit < 0) begin
						r.status = ST_NOT_FOUND;
					end else begin
						r.position = POS_W'(hit);
						if (f == FN_REMOVE)
							deque_keys.delete(hit);
					end
				end
			end
			FN_CLEAR: deque_keys.delete();
			default: r.status = ST_INVALID;
		endcase
		r.occupancy = OCC_W'(deque_keys.size());
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		deque_result_t got;
		deque_result_t want;
		if (!arst_n) begin
			deque_keys.delete();
			expected_results.delete();
			fail_count     = 0;
			mismatch_count = 0;
			pending_count  = 0;
		end else begin
			if (done) begin
				got = {status, key_out, position, occupancy};
				if (expected_results.size() == 0) begin
					fail_count++;
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result: status %0d key_out %h position %0d occupancy %0d",
							got.status, got.key_out, got.position, got.occupancy);
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						fail_count++;
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("mismatch: expected status %0d key_out %h position %0d occupancy %0d, got status %0d key_out %h position %0d occupancy %0d",
								want.status, want.key_out, want.position, want.occupancy,
								got.status, got.key_out, got.position, got.occupancy);
					end
				end
			end
			if (start && !busy)
				expected_results.push_back(apply_request(func, key));
			pending_count = expected_results.size();
		end
	end

endmodule

// ===== tb/tb_top.sv =====
// testbench top: clock, reset, request stimulus, watchdog and verdict
`timescale 1ns / 100ps

module tb_top;
	import kdq_pkg::*;

	localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;
	localparam int RANDOM_REQUESTS = 1750;
	localparam int STALL_LIMIT     = 200;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic [FUNC_W-1:0] func;
	logic [KEY_W-1:0]  key;
	logic              busy;
	logic              done;
	logic [STAT_W-1:0] status;
	logic [KEY_W-1:0]  key_out;
	logic [POS_W-1:0]  position;
	logic [OCC_W-1:0]  occupancy;
	int                fail_count;
	int                pending_count;
	int                quiet_cycles;
	bit                gaps_on;
	logic [KEY_W-1:0]  key_pool[12];

	keyed_deque_with_removal uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.func      (func),
		.key       (key),
		.busy      (busy),
		.done      (done),
		.status    (status),
		.key_out   (key_out),
		.position  (position),
		.occupancy (occupancy)
	);

	kdq_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.func          (func),
		.key           (key),
		.done          (done),
		.status        (status),
		.key_out       (key_out),
		.position      (position),
		.occupancy     (occupancy),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_request(input logic [FUNC_W-1:0] f, input logic [KEY_W-1:0] k);
		start <= 1'b1;
		func  <= f;
		key   <= k;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (gaps_on && $urandom_range(99) < 21) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4))
				@(posedge clk);
		end
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		int r;
		r = $urandom_range(99);
		if (r < 5)
			return '0;
		else if (r < 75)
			return key_pool[$urandom_range(0, 11)];
		else
			return {$urandom, $urandom};
	endfunction

	initial begin
		int               r;
		int               push_pct;
		logic [FUNC_W-1:0] f;
		arst_n       = 1'b0;
		start        = 1'b0;
		func         = '0;
		key          = '0;
		gaps_on      = 1'b1;
		foreach (key_pool[i])
			key_pool[i] = {$urandom, $urandom} | 64'd1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue, zero keys and the unused code
		send_request(FN_POP_FRONT, '0);
		send_request(FN_POP_BACK, '0);
		send_request(FN_FIND, 64'd5);
		send_request(FN_REMOVE, 64'd5);
		send_request(FN_PUSH_FRONT, '0);
		send_request(FN_PUSH_BACK, '0);
		send_request(FN_FIND, '0);
		send_request(FN_REMOVE, '0);
		send_request(FN_UNUSED, '1);
		// extremes and duplicates
		send_request(FN_PUSH_FRONT, '1);
		send_request(FN_PUSH_BACK, 64'd1);
		send_request(FN_PUSH_FRONT, 64'h8000_0000_0000_0000);
		send_request(FN_PUSH_BACK, 64'd1);
		send_request(FN_FIND, 64'd1);
		send_request(FN_REMOVE, 64'd1);
		send_request(FN_FIND, 64'd1);
		send_request(FN_POP_BACK, '0);
		send_request(FN_POP_FRONT, '0);
		send_request(FN_REMOVE, 64'h5555_5555_5555_5555);
		// fill to capacity, then push into a full queue
		for (int i = 1; i < DEF_CAPACITY; i++)
			send_request(FN_PUSH_BACK, 64'hAAAA_AAAA_AAAA_AAA0 + i);
		send_request(FN_PUSH_FRONT, 64'h1234);
		send_request(FN_PUSH_BACK, '0);
		send_request(FN_FIND, 64'hAAAA_AAAA_AAAA_AAAF);
		send_request(FN_POP_BACK, '0);
		send_request(FN_CLEAR, '0);
		send_request(FN_POP_FRONT, '0);

		push_pct = 60;
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n % 40 == 0)
				push_pct = (push_pct == 60) ? 15 : 60;
			gaps_on = !(n >= 600 && n < 900);
			r = $urandom_range(99);
			if (r < 2)
				f = FN_CLEAR;
			else if (r < 4)
				f = FN_UNUSED;
			else if (r < 4 + push_pct)
				f = $urandom_range(1) ? FN_PUSH_BACK : FN_PUSH_FRONT;
			else
				f = FUNC_W'($urandom_range(FN_POP_FRONT, FN_FIND));
			send_request(f, pick_key());
		end
		start <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/kdq_pkg.sv
rtl/kdq_cell.sv
rtl/keyed_deque_with_removal.sv
tb/kdq_checker.sv
tb/tb_top.sv
